[rtl/lgac_pkg.sv]
package lgac_pkg;

	// field widths
	localparam int POS_W      = 20;
	localparam int LEN_W      = 13;
	localparam int SPD_W      = 14;
	localparam int CMD_W      = 2;
	localparam int JAM_W      = 11;
	localparam int BRAKE_W    = 12;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 1;

	// default lane table depth
	localparam int LGAC_LANE_SLOTS = 64;

	// gap arithmetic widths: twice the bumper gap, product, squared speed difference
	localparam int G2_W   = POS_W + 1;
	localparam int DV_W   = SPD_W + 1;
	localparam int PROD_W = G2_W + SPD_W;
	localparam int DV2_W  = 2 * SPD_W;

	// command codes
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_JAM_DISTANCE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HARD_BRAKE   = 1'b1;

	// register reset values
	localparam logic [JAM_W-1:0]   JAM_RESET   = 11'd512;
	localparam logic [BRAKE_W-1:0] BRAKE_RESET = 12'd2048;

	// smallest margin used in the braking compare (one unit, doubled)
	localparam logic [G2_W-1:0] MIN_MARGIN = 21'd2;

	// one vehicle
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [LEN_W-1:0] len;
		logic [SPD_W-1:0] spd;
	} lane_entry_t;

	// sequencer to gap unit
	typedef struct packed {
		logic start;
		logic newcomer_behind;
	} gap_ctrl_t;

	// gap unit to sequencer
	typedef struct packed {
		logic done;
		logic pass;
	} gap_stat_t;

endpackage

[rtl/lgac_gap_unit.sv]
module lgac_gap_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lgac_pkg::gap_ctrl_t           ctrl,
	input  lgac_pkg::lane_entry_t         table_entry,
	input  lgac_pkg::lane_entry_t         newcomer,
	input  logic [lgac_pkg::JAM_W-1:0]    jam_distance,
	input  logic [lgac_pkg::BRAKE_W-1:0]  hard_brake,
	output lgac_pkg::gap_stat_t           stat
);
	import lgac_pkg::*;

	typedef enum logic [4:0] {
		G_IDLE   = 5'b00001,
		G_MARGIN = 5'b00010,
		G_SQUARE = 5'b00100,
		G_BRAKE  = 5'b01000,
		G_CMP    = 5'b10000
	} gap_state_t;

	gap_state_t               state_q;
	lane_entry_t              front;
	lane_entry_t              rear;
	logic [LEN_W:0]           len_sum;
	logic signed [G2_W+1:0]   g2_raw;
	logic [G2_W-1:0]          g2_floor;
	logic signed [DV_W-1:0]   dv_raw;
	logic [G2_W-1:0]          g2_q;
	logic signed [DV_W-1:0]   dv_q;
	logic [G2_W-1:0]          jam2;
	logic [G2_W-1:0]          margin;
	logic                     jam_fail;
	logic                     closing;
	logic [G2_W-1:0]          m_q;
	logic [G2_W-1:0]          mul_a;
	logic [SPD_W-1:0]         mul_b;
	logic [PROD_W-1:0]        prod_w;
	logic [PROD_W-1:0]        prod_q;
	logic [DV2_W-1:0]         dv2_q;
	logic                     done_q;
	logic                     pass_q;

	// pick front and rear vehicle of the pair
	assign front = ctrl.newcomer_behind ? table_entry : newcomer;
	assign rear  = ctrl.newcomer_behind ? newcomer : table_entry;

	// twice the bumper gap, floored at zero, and the speed difference
	assign len_sum  = {1'b0, front.len} + {1'b0, rear.len};
	assign g2_raw   = $signed({2'b00, front.pos, 1'b0}) - $signed({2'b00, rear.pos, 1'b0})
	                - $signed({{(G2_W+1-LEN_W){1'b0}}, len_sum});
	assign g2_floor = g2_raw[G2_W+1] ? '0 : g2_raw[G2_W-1:0];
	assign dv_raw   = $signed({1'b0, rear.spd}) - $signed({1'b0, front.spd});

	// jam distance check and braking margin
	assign jam2     = {{(G2_W-JAM_W-1){1'b0}}, jam_distance, 1'b0};
	assign jam_fail = g2_q < jam2;
	assign closing  = !dv_q[DV_W-1] && (dv_q != '0);
	assign margin   = g2_q - jam2;

	// shared multiplier: squared speed difference, then brake times margin
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			G_SQUARE: begin
				mul_a = {{(G2_W-SPD_W){1'b0}}, dv_q[SPD_W-1:0]};
				mul_b = dv_q[SPD_W-1:0];
			end
			G_BRAKE: begin
				mul_a = m_q;
				mul_b = {{(SPD_W-BRAKE_W){1'b0}}, hard_brake};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_w = {{SPD_W{1'b0}}, mul_a} * {{G2_W{1'b0}}, mul_b};

	// check sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			done_q  <= 1'b0;
			pass_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				G_IDLE: begin
					if (ctrl.start) begin
						state_q <= G_MARGIN;
					end
				end
				G_MARGIN: begin
					if (jam_fail) begin
						done_q  <= 1'b1;
						pass_q  <= 1'b0;
						state_q <= G_IDLE;
					end else if (!closing) begin
						done_q  <= 1'b1;
						pass_q  <= 1'b1;
						state_q <= G_IDLE;
					end else begin
						state_q <= G_SQUARE;
					end
				end
				G_SQUARE: begin
					state_q <= G_BRAKE;
				end
				G_BRAKE: begin
					state_q <= G_CMP;
				end
				G_CMP: begin
					done_q  <= 1'b1;
					pass_q  <= {{(PROD_W-DV2_W){1'b0}}, dv2_q} <= prod_q;
					state_q <= G_IDLE;
				end
				default: begin
					state_q <= G_IDLE;
				end
			endcase
		end
	end

	// operand and product registers
	always_ff @(posedge clk) begin
		if (state_q == G_IDLE && ctrl.start) begin
			g2_q <= g2_floor;
			dv_q <= dv_raw;
		end
		if (state_q == G_MARGIN) begin
			m_q <= (margin < MIN_MARGIN) ? MIN_MARGIN : margin;
		end
		if (state_q == G_SQUARE || state_q == G_BRAKE) begin
			prod_q <= prod_w;
		end
		if (state_q == G_BRAKE) begin
			dv2_q <= prod_q[DV2_W-1:0];
		end
	end

	assign stat.done = done_q;
	assign stat.pass = pass_q;

endmodule

[rtl/lane_gap_acceptance_check_top.sv]
// Lane gap acceptance check. Commands come in one at a time: clear the lane table,
// append a vehicle (entries must go in by descending position), or query whether a
// newcomer fits between its leader and follower. Every command gives one result.
// Clear, append and no-op pass from the transfer through S_DONE into the output
// register. A query runs a binary search over the table (up to log2(entries)+1
// probes, one table read each), then per present neighbour reads the entry and
// starts the check in the shared gap unit, whose one multiplier forms dv*dv and
// then hard_brake*margin in turn, and waits for its result. The input is stalled
// while a command is worked on; one finished result may wait in the output register
// while the next command is taken.
module lane_gap_acceptance_check_top #(
	parameter int LANE_SLOTS = lgac_pkg::LGAC_LANE_SLOTS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [lgac_pkg::CMD_W-1:0]       command,
	input  logic [lgac_pkg::POS_W-1:0]       position,
	input  logic [lgac_pkg::LEN_W-1:0]       vehicle_length,
	input  logic [lgac_pkg::SPD_W-1:0]       speed,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             gap_acceptable,
	output logic                             leader_present,
	output logic                             follower_present,
	output logic                             status,
	input  logic                             cfg_we,
	input  logic [lgac_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lgac_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import lgac_pkg::*;

	localparam int AW = (LANE_SLOTS > 1) ? $clog2(LANE_SLOTS) : 1;
	localparam int CW = $clog2(LANE_SLOTS + 1);

	typedef enum logic [8:0] {
		S_IDLE      = 9'b000000001,
		S_SEARCH    = 9'b000000010,
		S_LEAD_RD   = 9'b000000100,
		S_LEAD_GO   = 9'b000001000,
		S_LEAD_WAIT = 9'b000010000,
		S_FOLL_RD   = 9'b000100000,
		S_FOLL_GO   = 9'b001000000,
		S_FOLL_WAIT = 9'b010000000,
		S_DONE      = 9'b100000000
	} seq_state_t;

	seq_state_t          state_q;
	logic [JAM_W-1:0]    jam_q;
	logic [BRAKE_W-1:0]  brake_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       first_q;
	logic [CW-1:0]       span_q;
	lane_entry_t         new_q;
	lane_entry_t         in_entry;
	lane_entry_t         lane_mem [LANE_SLOTS];
	lane_entry_t         rd_data_q;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic                in_xfer;
	logic                out_free;
	logic                table_full;
	logic [CW-1:0]       step;
	logic [CW-1:0]       probe;
	logic                probe_ahead;
	logic [CW-1:0]       first_n;
	logic [CW-1:0]       span_n;
	logic [CW-1:0]       next_probe;
	logic [CW-1:0]       lead_idx;
	logic                ok_q;
	logic                lead_q;
	logic                foll_q;
	logic                status_q;
	logic                out_valid_q;
	logic                out_ok_q;
	logic                out_lead_q;
	logic                out_foll_q;
	logic                out_status_q;
	gap_ctrl_t           gap_ctrl;
	gap_stat_t           gap_stat;

	assign in_entry   = '{pos: position, len: vehicle_length, spd: speed};
	assign in_stall   = (state_q != S_IDLE);
	assign in_xfer    = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign table_full = (count_q == CW'(LANE_SLOTS));
	assign wr_en      = in_xfer && (command == CMD_APPEND) && !table_full;

	// binary search step on the entry read last cycle
	assign step        = span_q >> 1;
	assign probe       = first_q + step;
	assign probe_ahead = rd_data_q.pos > new_q.pos;
	assign first_n     = probe_ahead ? probe + CW'(1) : first_q;
	assign span_n      = probe_ahead ? span_q - step - CW'(1) : step;
	assign next_probe  = first_n + (span_n >> 1);
	assign lead_idx    = first_q - CW'(1);

	// table read address per state
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			S_IDLE: begin
				rd_en   = in_xfer && (command == CMD_QUERY) && (count_q != '0);
				rd_addr = AW'(count_q >> 1);
			end
			S_SEARCH: begin
				rd_en   = (span_n != '0);
				rd_addr = next_probe[AW-1:0];
			end
			S_LEAD_RD: begin
				rd_en   = (first_q != '0);
				rd_addr = lead_idx[AW-1:0];
			end
			S_FOLL_RD: begin
				rd_en   = (first_q < count_q);
				rd_addr = first_q[AW-1:0];
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = '0;
			end
		endcase
	end

	// lane table
	always_ff @(posedge clk) begin
		if (wr_en) begin
			lane_mem[count_q[AW-1:0]] <= in_entry;
		end
		if (rd_en) begin
			rd_data_q <= lane_mem[rd_addr];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jam_q   <= JAM_RESET;
			brake_q <= BRAKE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_JAM_DISTANCE: jam_q   <= cfg_data[JAM_W-1:0];
				REG_HARD_BRAKE:   brake_q <= cfg_data[BRAKE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// newcomer held for the whole query
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			new_q <= in_entry;
		end
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			first_q  <= '0;
			span_q   <= '0;
			ok_q     <= 1'b0;
			lead_q   <= 1'b0;
			foll_q   <= 1'b0;
			status_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						ok_q     <= 1'b0;
						lead_q   <= 1'b0;
						foll_q   <= 1'b0;
						status_q <= 1'b0;
						case (command)
							CMD_CLEAR: begin
								count_q <= '0;
								state_q <= S_DONE;
							end
							CMD_APPEND: begin
								if (table_full) begin
									status_q <= 1'b1;
								end else begin
									count_q <= count_q + CW'(1);
								end
								state_q <= S_DONE;
							end
							CMD_QUERY: begin
								ok_q    <= 1'b1;
								first_q <= '0;
								span_q  <= count_q;
								state_q <= (count_q != '0) ? S_SEARCH : S_LEAD_RD;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SEARCH: begin
					first_q <= first_n;
					span_q  <= span_n;
					if (span_n == '0) begin
						state_q <= S_LEAD_RD;
					end
				end
				S_LEAD_RD: begin
					lead_q  <= (first_q != '0);
					foll_q  <= (first_q < count_q);
					state_q <= (first_q != '0) ? S_LEAD_GO : S_FOLL_RD;
				end
				S_LEAD_GO: begin
					state_q <= S_LEAD_WAIT;
				end
				S_LEAD_WAIT: begin
					if (gap_stat.done) begin
						if (gap_stat.pass) begin
							state_q <= S_FOLL_RD;
						end else begin
							ok_q    <= 1'b0;
							state_q <= S_DONE;
						end
					end
				end
				S_FOLL_RD: begin
					state_q <= (first_q < count_q) ? S_FOLL_GO : S_DONE;
				end
				S_FOLL_GO: begin
					state_q <= S_FOLL_WAIT;
				end
				S_FOLL_WAIT: begin
					if (gap_stat.done) begin
						ok_q    <= gap_stat.pass;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// shared gap unit
	assign gap_ctrl.start           = (state_q == S_LEAD_GO) || (state_q == S_FOLL_GO);
	assign gap_ctrl.newcomer_behind = (state_q == S_LEAD_GO);

	lgac_gap_unit u_gap_unit (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (gap_ctrl),
		.table_entry  (rd_data_q),
		.newcomer     (new_q),
		.jam_distance (jam_q),
		.hard_brake   (brake_q),
		.stat         (gap_stat)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_ok_q     <= ok_q;
			out_lead_q   <= lead_q;
			out_foll_q   <= foll_q;
			out_status_q <= status_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign gap_acceptable   = out_ok_q;
	assign leader_present   = out_lead_q;
	assign follower_present = out_foll_q;
	assign status           = out_status_q;

endmodule

[rtl/lgac_checker.sv]
module lgac_checker (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  in_stall,
	input  logic  out_valid,
	input  logic  out_stall,
	input  logic  gap_acceptable,
	input  logic  leader_present,
	input  logic  follower_present,
	input  logic  status
);

	// a stalled result stays offered
	a_out_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	// a stalled result keeps its fields
	a_out_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(gap_acceptable) && $stable(leader_present)
			&& $stable(follower_present) && $stable(status))
		else $error("result fields changed while stalled");

	// one command at a time: busy right after an input transfer
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again before the command finished");

	// a dropped append carries no query flags
	a_status_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> !gap_acceptable && !leader_present && !follower_present)
		else $error("append status mixed with query flags");

endmodule

bind lane_gap_acceptance_check_top lgac_checker u_lgac_checker (.*);
